// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH    = 64;
  localparam int KEY_BITS = 32;
  localparam int ID_BITS  = 16;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic                do_ins;
    logic                do_pop;
    logic                do_rem;
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } ctl_t;

endpackage

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, compares it against the
// command and takes its own, its left or its right neighbour's entry, or the inserted one.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  ctl_t   ctl,
  input  entry_t left,
  input  logic   left_ge,
  input  entry_t right,
  input  logic   hit_in,
  output entry_t cur,
  output logic   ge,
  output logic   hit_out,
  output entry_t sel
);

  logic                valid_r, valid_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic                take;

  assign cur.valid = valid_r;
  assign cur.key   = key_r;
  assign cur.id    = id_r;

  assign ge      = valid_r & (key_r >= ctl.key);
  assign take    = valid_r & (ctl.do_pop | (ctl.do_rem & (id_r == ctl.id)));
  assign hit_out = hit_in | take;

  assign sel.valid = take & ~hit_in;
  assign sel.key   = sel.valid ? key_r : '0;
  assign sel.id    = sel.valid ? id_r : '0;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    id_nxt    = id_r;
    if (ctl.do_ins) begin
      if (left_ge) begin
        valid_nxt = left.valid;
        key_nxt   = left.key;
        id_nxt    = left.id;
      end else if (ge || (left.valid && !valid_r)) begin
        valid_nxt = 1'b1;
        key_nxt   = ctl.key;
        id_nxt    = ctl.id;
      end
    end else if (hit_out) begin
      valid_nxt = right.valid;
      key_nxt   = right.key;
      id_nxt    = right.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
  end

endmodule

// File: rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted (key, id) list with insert, pop-minimum and remove-by-id.
// Output: result registered in the cycle after the input transaction.
// Throughput: one transaction per cycle; the whole cell row updates in the
// accepting cycle, and the output register stalls input only when held.
// Reset: clears the slot valid bits, the count and the output valid flag;
// no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // key[31:0], item_id[47:32]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // out_id[15:0], out_key[47:16], status[49:48],
                                  // fill[56:50], is_empty[57], zero pad
);

  ctl_t                ctl;
  entry_t              row   [DEPTH+1];
  entry_t              right [DEPTH];
  entry_t              sel   [DEPTH];
  logic                ge    [DEPTH+1];
  logic                hit   [DEPTH+1];
  logic                accept;
  logic                full, empty, found;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [1:0]          status;
  logic [KEY_BITS-1:0] sel_key;
  logic [ID_BITS-1:0]  sel_id;
  logic                out_valid_r;
  logic [ID_BITS-1:0]  out_id_r;
  logic [KEY_BITS-1:0] out_key_r;
  logic [1:0]          status_r;
  logic [CNT_BITS-1:0] fill_r;

  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;
  assign full      = (count_r == CNT_BITS'(DEPTH));
  assign empty     = (count_r == '0);

  assign ctl.key    = in_tdata[KEY_BITS-1:0];
  assign ctl.id     = in_tdata[KEY_BITS+ID_BITS-1:KEY_BITS];
  assign ctl.do_ins = accept & (in_tuser == CMD_INSERT) & ~full;
  assign ctl.do_pop = accept & (in_tuser == CMD_POP) & ~empty;
  assign ctl.do_rem = accept & (in_tuser == CMD_REMOVE);

  // head of the row: a valid, never-greater left neighbour
  assign row[0] = '{valid: 1'b1, key: '0, id: '0};
  assign ge[0]  = 1'b0;
  assign hit[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_tail
        assign right[g] = '{valid: 1'b0, key: '0, id: '0};
      end else begin : g_mid
        assign right[g] = row[g+2];
      end
      spq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .left    (row[g]),
        .left_ge (ge[g]),
        .right   (right[g]),
        .hit_in  (hit[g]),
        .cur     (row[g+1]),
        .ge      (ge[g+1]),
        .hit_out (hit[g+1]),
        .sel     (sel[g])
      );
    end
  endgenerate

  assign found = hit[DEPTH];

  always_comb begin
    sel_key = '0;
    sel_id  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_key = sel_key | sel[i].key;
      sel_id  = sel_id | sel[i].id;
    end
  end

  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    case (in_tuser)
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP: begin
        if (empty) begin
          status = ST_POP_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          count_nxt = count_r - 1'b1;
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_id_r  <= sel_id;
      out_key_r <= sel_key;
      status_r  <= status;
      fill_r    <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, (fill_r == '0), fill_r, status_r, out_key_r, out_id_r};

endmodule

// File: bench/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted (key, id) priority queue. A directed
// preamble covers the empty, duplicate and extreme cases. Phased random
// traffic follows, filling the queue to capacity, removing by id and draining
// it again. A scoreboard keeps its own sorted copy of the queue and checks
// every result transaction field by field. Both stream sides idle at random,
// and the result side stalls for one long stretch to back-pressure the input.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_IDLE     = 18;

  typedef struct packed {
    logic [5:0]          pad;
    logic                is_empty;
    logic [CNT_BITS-1:0] fill;
    logic [1:0]          status;
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } result_t;

  typedef enum {PH_FILL, PH_REMOVE, PH_DRAIN, PH_MIXED} phase_t;

  class spq_scoreboard;
    logic [KEY_BITS-1:0] held_keys[$];
    logic [ID_BITS-1:0]  held_ids[$];
    result_t             pending_results[$];
    int                  errors;
    int                  results_checked;
    int                  peak_fill;
    int                  cmd_count[4];
    int                  status_count[4];

    // Applies one accepted command to the shadow queue and records the
    // result the block must return for it.
    function void note_command(logic [1:0] cmd, logic [KEY_BITS-1:0] key,
                               logic [ID_BITS-1:0] id);
      result_t r;
      int      pos;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          if (held_keys.size() >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            pos = held_keys.size();
            for (int i = 0; i < held_keys.size(); i++) begin
              if (held_keys[i] >= key) begin
                pos = i;
                break;
              end
            end
            held_keys.insert(pos, key);
            held_ids.insert(pos, id);
          end
        end
        CMD_POP: begin
          if (held_keys.size() == 0) begin
            r.status = ST_POP_EMPTY;
          end else begin
            r.key = held_keys[0];
            r.id  = held_ids[0];
            held_keys.delete(0);
            held_ids.delete(0);
          end
        end
        CMD_REMOVE: begin
          pos = -1;
          for (int i = 0; i < held_ids.size(); i++) begin
            if (held_ids[i] == id) begin
              pos = i;
              break;
            end
          end
          if (pos < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.key = held_keys[pos];
            r.id  = held_ids[pos];
            held_keys.delete(pos);
            held_ids.delete(pos);
          end
        end
        default: ;
      endcase
      r.fill     = CNT_BITS'(held_keys.size());
      r.is_empty = (held_keys.size() == 0);
      if (held_keys.size() > peak_fill) peak_fill = held_keys.size();
      cmd_count[cmd]++;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      results_checked++;
      status_count[want.status]++;
      if (got.id !== want.id) begin
        $error("out_id: expected %0d, got %0d", want.id, got.id);
        errors++;
      end
      if (got.key !== want.key) begin
        $error("out_key: expected %h, got %h", want.key, got.key);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.fill !== want.fill) begin
        $error("fill: expected %0d, got %0d", want.fill, got.fill);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        errors++;
      end
      if (got.pad !== want.pad) begin
        $error("pad: expected %h, got %h", want.pad, got.pad);
        errors++;
      end
    endfunction

    function logic [ID_BITS-1:0] pick_held_id();
      if (held_ids.size() == 0) return ID_BITS'($urandom_range(0, 65535));
      return held_ids[$urandom_range(0, held_ids.size() - 1)];
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // key[31:0], item_id[47:32]
  logic [1:0]  in_tuser;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // out_id[15:0], out_key[47:16], status[49:48],
                           // fill[56:50], is_empty[57], zero pad

  spq_scoreboard sb;
  bit            no_idle;
  bit            hold_off_request;
  int            quiet_cycles;

  sorted_priority_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_command(in_tuser, in_tdata[31:0], in_tdata[47:32]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(result_t'(out_tdata));
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls per transaction, one long hold-off on request.
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end
      @(negedge clk);
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_command(logic [1:0] cmd, logic [KEY_BITS-1:0] key,
                              logic [ID_BITS-1:0] id);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {id, key};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [KEY_BITS-1:0] draw_key();
    case ($urandom_range(0, 7))
      0, 1: return KEY_BITS'($urandom_range(0, 15));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [ID_BITS-1:0] draw_id();
    case ($urandom_range(0, 7))
      0, 1: return ID_BITS'($urandom_range(0, 7));
      2: return '1;
      default: return ID_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic run_phase(phase_t mode, int n);
    int ins_pct;
    int pop_pct;
    int rem_pct;
    int roll;
    case (mode)
      PH_FILL: begin
        ins_pct = 86; pop_pct = 5; rem_pct = 5;
      end
      PH_REMOVE: begin
        ins_pct = 25; pop_pct = 10; rem_pct = 61;
      end
      PH_DRAIN: begin
        ins_pct = 10; pop_pct = 76; rem_pct = 10;
      end
      default: begin
        ins_pct = 35; pop_pct = 31; rem_pct = 30;
      end
    endcase
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        send_command(CMD_INSERT, draw_key(), draw_id());
      end else if (roll < ins_pct + pop_pct) begin
        send_command(CMD_POP, KEY_BITS'($urandom), ID_BITS'($urandom_range(0, 65535)));
      end else if (roll < ins_pct + pop_pct + rem_pct) begin
        send_command(CMD_REMOVE, KEY_BITS'($urandom),
                     ($urandom_range(0, 3) != 0) ? sb.pick_held_id() : draw_id());
      end else begin
        send_command(CMD_UNUSED, KEY_BITS'($urandom), ID_BITS'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    int     sent;
    int     n;
    int     phase_idx;
    phase_t mode;
    sb               = new();
    no_idle          = 1'b0;
    hold_off_request = 1'b0;
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = CMD_INSERT;
    out_tready       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed preamble: empty queue, extremes, equal keys, duplicate ids.
    send_command(CMD_POP,    '0, '0);
    send_command(CMD_REMOVE, '0, '0);
    send_command(CMD_UNUSED, '1, '1);
    send_command(CMD_INSERT, '0, '0);
    send_command(CMD_INSERT, '1, '1);
    send_command(CMD_INSERT, 32'd5, 16'd1);
    send_command(CMD_INSERT, 32'd5, 16'd2);
    send_command(CMD_INSERT, 32'd5, 16'd1);
    send_command(CMD_INSERT, 32'h8000_0000, 16'h8000);
    send_command(CMD_UNUSED, 32'h1234_5678, 16'h00FF);
    send_command(CMD_REMOVE, 32'hFFFF_0000, 16'd1);
    send_command(CMD_REMOVE, 32'd0, 16'h1234);
    send_command(CMD_REMOVE, 32'd7, 16'hFFFF);
    send_command(CMD_POP,    '1, '1);
    send_command(CMD_POP,    '0, '0);
    send_command(CMD_POP,    '0, '0);
    send_command(CMD_POP,    '0, '0);
    send_command(CMD_POP,    '0, '0);
    send_command(CMD_REMOVE, '0, 16'd2);

    sent      = 0;
    phase_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = phase_t'(phase_idx % 4);
      n = (mode == PH_FILL) ? 100 : $urandom_range(50, 90);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      no_idle = ($urandom_range(0, 2) == 0);
      if (phase_idx == 1) hold_off_request = 1'b1;
      run_phase(mode, n);
      sent += n;
      phase_idx++;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d commands: %0d insert, %0d pop, %0d remove, %0d unused; peak fill %0d",
             sb.cmd_count[0] + sb.cmd_count[1] + sb.cmd_count[2] + sb.cmd_count[3],
             sb.cmd_count[CMD_INSERT], sb.cmd_count[CMD_POP], sb.cmd_count[CMD_REMOVE],
             sb.cmd_count[CMD_UNUSED], sb.peak_fill);
    $display("Checked %0d results: %0d ok, %0d pop-empty, %0d full, %0d id-absent",
             sb.results_checked, sb.status_count[ST_OK], sb.status_count[ST_POP_EMPTY],
             sb.status_count[ST_FULL], sb.status_count[ST_NOT_FOUND]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sorted_priority_queue.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
bench/sorted_priority_queue_tb.sv
